FILE: hdl/plmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plmt_pkg;

    localparam int POOL_NODES  = 65536;
    localparam int COORD_SLOTS = 4096;
    localparam int MAX_LEVELS  = 48;

    localparam int NODE_AW  = $clog2(POOL_NODES);
    localparam int HANDLE_W = 17;
    localparam int COORD_AW = $clog2(COORD_SLOTS);
    localparam int POS_W    = COORD_AW + 1;
    localparam int STACK_AW = $clog2(MAX_LEVELS);
    localparam int DEPTH_W  = $clog2(MAX_LEVELS + 1);
    localparam int CNT_W    = 13;
    localparam int SLOPE_W  = 32;
    localparam int VALUE_W  = 64;
    localparam int X_W      = 31;
    localparam int SLOT_W   = 12;
    localparam int NEED_W   = DEPTH_W + 1;

    localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = 64'sd1000000000000000000;

    typedef enum logic [1:0] {
        ACT_LOAD,
        ACT_INSERT,
        ACT_QUERY,
        ACT_SET_TOP
    } action_t;

    typedef enum logic [1:0] {
        KIND_LEAF,
        KIND_REPLACE,
        KIND_REUSE
    } kind_t;

    typedef enum logic [1:0] {
        XS_LEFT,
        XS_RIGHT,
        XS_MID,
        XS_QUERY
    } xsel_t;

    typedef enum logic [2:0] {
        D_KL,
        D_QL,
        D_KR,
        D_QR,
        D_KM,
        D_QM,
        D_V
    } dst_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_TOP,
        S_I_CHECK,
        S_I_RDM,
        S_I_RDR,
        S_I_EVM,
        S_I_EVA,
        S_I_DECIDE,
        S_I_NEED,
        S_I_POP_CHK,
        S_I_POP_RD,
        S_I_POP_WR,
        S_Q_CHECK,
        S_Q_EVM,
        S_Q_EVA,
        S_Q_STEP,
        S_FIN
    } state_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [VALUE_W-1:0] intercept;
        logic [HANDLE_W-1:0]       left;
        logic [HANDLE_W-1:0]       right;
    } node_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [VALUE_W-1:0] intercept;
        logic [HANDLE_W-1:0]       keep;
        logic                      went_left;
    } frame_t;

    typedef struct packed {
        logic    capture;
        logic    coord_wr;
        logic    set_top;
        logic    node_rd;
        logic    coord_rd;
        xsel_t   coord_sel;
        logic    mul;
        logic    use_node;
        xsel_t   xsel;
        dst_t    dst;
        logic    add;
        logic    set_kind;
        kind_t   kind;
        logic    step;
        logic    set_full;
        logic    put_first;
        logic    take_p;
        logic    pop_rd;
        logic    pop_wr;
        logic    q_step;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    p_empty;
        logic    depth_max;
        logic    all_le;
        logic    all_ge;
        logic    fits;
        logic    reuse;
        logic    depth_zero;
    } status_t;

endpackage

`default_nettype wire

FILE: hdl/plmt_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface plmt_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [16:0]        root_handle;
    logic signed [31:0] slope;
    logic signed [63:0] intercept;
    logic [30:0]        x_value;
    logic [11:0]        coord_slot;
    logic [16:0]        new_top;

    modport source (output valid, action, root_handle, slope, intercept, x_value,
                    coord_slot, new_top, input ready);
    modport sink (input valid, action, root_handle, slope, intercept, x_value,
                  coord_slot, new_top, output ready);
endinterface

interface plmt_rsp_if;
    logic               valid;
    logic               ready;
    logic [16:0]        new_root;
    logic signed [63:0] min_value;
    logic [16:0]        pool_top_now;
    logic               pool_full;

    modport source (output valid, new_root, min_value, pool_top_now, pool_full,
                    input ready);
    modport sink (input valid, new_root, min_value, pool_top_now, pool_full,
                  output ready);
endinterface

interface plmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] coord_count;

    modport source (output valid, coord_count, input ready);
    modport sink (input valid, coord_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/persistent_min_line_tree_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Node pool of a persistent Li Chao tree answering minimum line queries; one
// transaction in and one out per request, handled one at a time. A query
// evaluates one line per tree level visited on the shared multiply and
// saturating add unit, reading nodes through the single read port of the node
// memory. An insert makes three coordinate reads and six line evaluations on
// that one unit per level walked, then writes back the nodes along the copied
// path. The next request is taken while a finished result still waits in the
// output register. Node and coordinate memories need no clearing after reset.
module persistent_min_line_tree_top (
    input  logic        clk,
    input  logic        rst_n,
    plmt_req_if.sink    req,
    plmt_rsp_if.source  rsp,
    plmt_cfg_if.sink    cfg
);

    plmt_pkg::cmd_t    cmd;
    plmt_pkg::status_t status;
    logic              req_ready;
    logic              rsp_valid;

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign cfg.ready = 1'b1;

    plmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    plmt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_action    (req.action),
        .in_root      (req.root_handle),
        .in_slope     (req.slope),
        .in_intercept (req.intercept),
        .in_x         (req.x_value),
        .in_slot      (req.coord_slot),
        .in_top       (req.new_top),
        .cfg_valid    (cfg.valid),
        .cfg_count    (cfg.coord_count),
        .out_new_root (rsp.new_root),
        .out_min      (rsp.min_value),
        .out_top      (rsp.pool_top_now),
        .out_full     (rsp.pool_full)
    );

endmodule

`default_nettype wire

FILE: hdl/plmt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module plmt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  plmt_pkg::status_t status,
    output plmt_pkg::cmd_t    cmd
);

    plmt_pkg::state_t state_reg;
    plmt_pkg::state_t state_next;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    logic             rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plmt_pkg::S_IDLE;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            plmt_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    case (status.act)
                        plmt_pkg::ACT_LOAD:   state_next = plmt_pkg::S_LOAD;
                        plmt_pkg::ACT_INSERT: state_next = plmt_pkg::S_I_CHECK;
                        plmt_pkg::ACT_QUERY:  state_next = plmt_pkg::S_Q_CHECK;
                        default:              state_next = plmt_pkg::S_TOP;
                    endcase
                end
            end
            plmt_pkg::S_LOAD:
            begin
                cmd.coord_wr = 1'b1;
                state_next   = plmt_pkg::S_FIN;
            end
            plmt_pkg::S_TOP:
            begin
                cmd.set_top = 1'b1;
                state_next  = plmt_pkg::S_FIN;
            end
            plmt_pkg::S_I_CHECK:
            begin
                if (status.p_empty || status.depth_max)
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = plmt_pkg::KIND_LEAF;
                    state_next   = plmt_pkg::S_I_NEED;
                end
                else
                begin
                    cmd.node_rd   = 1'b1;
                    cmd.coord_rd  = 1'b1;
                    cmd.coord_sel = plmt_pkg::XS_LEFT;
                    state_next    = plmt_pkg::S_I_RDM;
                end
            end
            plmt_pkg::S_I_RDM:
            begin
                cmd.coord_rd  = 1'b1;
                cmd.coord_sel = plmt_pkg::XS_MID;
                state_next    = plmt_pkg::S_I_RDR;
            end
            plmt_pkg::S_I_RDR:
            begin
                cmd.coord_rd  = 1'b1;
                cmd.coord_sel = plmt_pkg::XS_RIGHT;
                idx_next      = '0;
                state_next    = plmt_pkg::S_I_EVM;
            end
            plmt_pkg::S_I_EVM:
            begin
                // Even steps evaluate the new line, odd steps the stored one.
                cmd.mul      = 1'b1;
                cmd.use_node = idx_reg[0];
                cmd.xsel     = plmt_pkg::xsel_t'(idx_reg[2:1]);
                cmd.dst      = plmt_pkg::dst_t'(idx_reg);
                state_next   = plmt_pkg::S_I_EVA;
            end
            plmt_pkg::S_I_EVA:
            begin
                cmd.add = 1'b1;
                if (idx_reg == 3'(plmt_pkg::D_QM))
                begin
                    state_next = plmt_pkg::S_I_DECIDE;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = plmt_pkg::S_I_EVM;
                end
            end
            plmt_pkg::S_I_DECIDE:
            begin
                if (status.all_le)
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = plmt_pkg::KIND_REPLACE;
                    state_next   = plmt_pkg::S_I_NEED;
                end
                else if (status.all_ge)
                begin
                    cmd.set_kind = 1'b1;
                    cmd.kind     = plmt_pkg::KIND_REUSE;
                    state_next   = plmt_pkg::S_I_NEED;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = plmt_pkg::S_I_CHECK;
                end
            end
            plmt_pkg::S_I_NEED:
            begin
                if (!status.fits)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = plmt_pkg::S_FIN;
                end
                else if (status.reuse)
                begin
                    cmd.take_p = 1'b1;
                    state_next = plmt_pkg::S_I_POP_CHK;
                end
                else
                begin
                    cmd.put_first = 1'b1;
                    state_next    = plmt_pkg::S_I_POP_CHK;
                end
            end
            plmt_pkg::S_I_POP_CHK:
            begin
                if (status.depth_zero)
                begin
                    state_next = plmt_pkg::S_FIN;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = plmt_pkg::S_I_POP_WR;
                end
            end
            plmt_pkg::S_I_POP_WR:
            begin
                cmd.pop_wr = 1'b1;
                state_next = plmt_pkg::S_I_POP_CHK;
            end
            plmt_pkg::S_Q_CHECK:
            begin
                if (status.p_empty || status.depth_max)
                begin
                    state_next = plmt_pkg::S_FIN;
                end
                else
                begin
                    cmd.node_rd   = 1'b1;
                    cmd.coord_rd  = 1'b1;
                    cmd.coord_sel = plmt_pkg::XS_MID;
                    state_next    = plmt_pkg::S_Q_EVM;
                end
            end
            plmt_pkg::S_Q_EVM:
            begin
                cmd.mul      = 1'b1;
                cmd.use_node = 1'b1;
                cmd.xsel     = plmt_pkg::XS_QUERY;
                cmd.dst      = plmt_pkg::D_V;
                state_next   = plmt_pkg::S_Q_EVA;
            end
            plmt_pkg::S_Q_EVA:
            begin
                cmd.add    = 1'b1;
                state_next = plmt_pkg::S_Q_STEP;
            end
            plmt_pkg::S_Q_STEP:
            begin
                cmd.q_step = 1'b1;
                state_next = plmt_pkg::S_Q_CHECK;
            end
            plmt_pkg::S_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = plmt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/plmt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module plmt_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  plmt_pkg::cmd_t                         cmd,
    output plmt_pkg::status_t                      status,
    input  logic [1:0]                             in_action,
    input  logic [plmt_pkg::HANDLE_W-1:0]          in_root,
    input  logic signed [plmt_pkg::SLOPE_W-1:0]    in_slope,
    input  logic signed [plmt_pkg::VALUE_W-1:0]    in_intercept,
    input  logic [plmt_pkg::X_W-1:0]               in_x,
    input  logic [plmt_pkg::SLOT_W-1:0]            in_slot,
    input  logic [plmt_pkg::HANDLE_W-1:0]          in_top,
    input  logic                                   cfg_valid,
    input  logic [plmt_pkg::CNT_W-1:0]             cfg_count,
    output logic [plmt_pkg::HANDLE_W-1:0]          out_new_root,
    output logic signed [plmt_pkg::VALUE_W-1:0]    out_min,
    output logic [plmt_pkg::HANDLE_W-1:0]          out_top,
    output logic                                   out_full
);

    localparam logic [plmt_pkg::HANDLE_W-1:0] POOL_MAX = plmt_pkg::HANDLE_W'(plmt_pkg::POOL_NODES);
    localparam logic [plmt_pkg::CNT_W-1:0] SLOT_MAX = plmt_pkg::CNT_W'(plmt_pkg::COORD_SLOTS);

    plmt_pkg::node_t                        nmem [plmt_pkg::POOL_NODES];
    logic [plmt_pkg::X_W-1:0]               ctab [plmt_pkg::COORD_SLOTS];
    plmt_pkg::frame_t                       stk  [plmt_pkg::MAX_LEVELS];

    plmt_pkg::action_t                      act_reg;
    plmt_pkg::kind_t                        kind_reg;
    logic [plmt_pkg::CNT_W-1:0]             cnt_reg;
    logic [plmt_pkg::HANDLE_W-1:0]          pool_top_reg;
    logic [plmt_pkg::DEPTH_W-1:0]           depth_reg;
    logic                                   full_reg;
    logic [plmt_pkg::HANDLE_W-1:0]          root_reg;
    logic [plmt_pkg::HANDLE_W-1:0]          p_reg;
    logic signed [plmt_pkg::SLOPE_W-1:0]    s_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    b_reg;
    logic [plmt_pkg::X_W-1:0]               x_reg;
    logic [plmt_pkg::SLOT_W-1:0]            slot_reg;
    logic [plmt_pkg::HANDLE_W-1:0]          top_in_reg;
    logic [plmt_pkg::POS_W-1:0]             l_reg;
    logic [plmt_pkg::POS_W-1:0]             r_reg;
    logic [plmt_pkg::X_W-1:0]               xl_reg;
    logic [plmt_pkg::X_W-1:0]               xm_reg;
    logic [plmt_pkg::X_W-1:0]               xr_reg;
    plmt_pkg::node_t                        nd_reg;
    plmt_pkg::frame_t                       stk_q_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    prod_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    hold_reg;
    plmt_pkg::dst_t                         dst_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    kl_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    ql_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    kr_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    qr_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    km_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    qm_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    v_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    best_reg;
    logic [plmt_pkg::HANDLE_W-1:0]          result_reg;
    logic [plmt_pkg::HANDLE_W-1:0]          out_new_root_reg;
    logic signed [plmt_pkg::VALUE_W-1:0]    out_min_reg;
    logic [plmt_pkg::HANDLE_W-1:0]          out_top_reg;
    logic                                   out_full_reg;

    logic [plmt_pkg::POS_W-1:0]             m_w;
    logic [plmt_pkg::POS_W-1:0]             span_w;
    logic [plmt_pkg::POS_W-1:0]             cpos_w;
    logic                                   cpos_out_w;
    logic [plmt_pkg::NODE_AW-1:0]           p_addr_w;
    logic [plmt_pkg::NODE_AW-1:0]           put_addr_w;
    logic [plmt_pkg::HANDLE_W-1:0]          top_inc_w;
    logic signed [plmt_pkg::SLOPE_W-1:0]    mul_s_w;
    logic [plmt_pkg::X_W-1:0]               mul_x_w;
    logic signed [plmt_pkg::VALUE_W:0]      sum_w;
    logic signed [plmt_pkg::VALUE_W-1:0]    sat_w;
    logic                                   mid_w;
    logic                                   went_left_w;
    logic [plmt_pkg::NEED_W-1:0]            need_w;
    logic [plmt_pkg::HANDLE_W-1:0]          room_w;
    plmt_pkg::node_t                        wr_node_w;

    assign m_w        = plmt_pkg::POS_W'(({1'b0, l_reg} + {1'b0, r_reg}) >> 1);
    assign p_addr_w   = plmt_pkg::NODE_AW'(p_reg - plmt_pkg::HANDLE_W'(1));
    assign put_addr_w = pool_top_reg[plmt_pkg::NODE_AW-1:0];
    assign top_inc_w  = pool_top_reg + plmt_pkg::HANDLE_W'(1);

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            span_w = plmt_pkg::POS_W'(1);
        end
        else if (cnt_reg > SLOT_MAX)
        begin
            span_w = plmt_pkg::POS_W'(plmt_pkg::COORD_SLOTS);
        end
        else
        begin
            span_w = plmt_pkg::POS_W'(cnt_reg);
        end
    end

    always_comb
    begin
        case (cmd.coord_sel)
            plmt_pkg::XS_LEFT:  cpos_w = l_reg;
            plmt_pkg::XS_RIGHT: cpos_w = r_reg;
            default:            cpos_w = m_w;
        endcase
    end

    // A position past the last table slot reads as coordinate zero.
    assign cpos_out_w = cpos_w > plmt_pkg::POS_W'(plmt_pkg::COORD_SLOTS);

    always_comb
    begin
        mul_s_w = cmd.use_node ? nd_reg.slope : s_reg;
        case (cmd.xsel)
            plmt_pkg::XS_LEFT:  mul_x_w = xl_reg;
            plmt_pkg::XS_RIGHT: mul_x_w = xr_reg;
            plmt_pkg::XS_MID:   mul_x_w = xm_reg;
            default:            mul_x_w = x_reg;
        endcase
    end

    // The sum is exact in one extra bit; a sign mismatch of the top two bits
    // means it left the 64-bit range and is clamped.
    assign sum_w = {prod_reg[plmt_pkg::VALUE_W-1], prod_reg}
                 + {hold_reg[plmt_pkg::VALUE_W-1], hold_reg};

    always_comb
    begin
        if (sum_w[plmt_pkg::VALUE_W] != sum_w[plmt_pkg::VALUE_W-1])
        begin
            sat_w = sum_w[plmt_pkg::VALUE_W] ? {1'b1, {(plmt_pkg::VALUE_W-1){1'b0}}}
                                              : {1'b0, {(plmt_pkg::VALUE_W-1){1'b1}}};
        end
        else
        begin
            sat_w = sum_w[plmt_pkg::VALUE_W-1:0];
        end
    end

    assign mid_w       = km_reg < qm_reg;
    assign went_left_w = (kl_reg < ql_reg) != mid_w;
    assign need_w      = plmt_pkg::NEED_W'(depth_reg)
                       + ((kind_reg == plmt_pkg::KIND_REUSE) ? plmt_pkg::NEED_W'(0)
                                                            : plmt_pkg::NEED_W'(1));
    assign room_w      = POOL_MAX - pool_top_reg;

    always_comb
    begin
        wr_node_w = '0;
        if (cmd.put_first)
        begin
            wr_node_w.slope     = s_reg;
            wr_node_w.intercept = b_reg;
            if (kind_reg == plmt_pkg::KIND_REPLACE)
            begin
                wr_node_w.left  = nd_reg.left;
                wr_node_w.right = nd_reg.right;
            end
        end
        else
        begin
            wr_node_w.slope     = stk_q_reg.slope;
            wr_node_w.intercept = stk_q_reg.intercept;
            wr_node_w.left      = stk_q_reg.went_left ? result_reg : stk_q_reg.keep;
            wr_node_w.right     = stk_q_reg.went_left ? stk_q_reg.keep : result_reg;
        end
    end

    always_comb
    begin
        status.act        = plmt_pkg::action_t'(in_action);
        status.p_empty    = (p_reg == '0) || (p_reg > pool_top_reg);
        status.depth_max  = depth_reg >= plmt_pkg::DEPTH_W'(plmt_pkg::MAX_LEVELS);
        status.all_le     = (kl_reg <= ql_reg) && (kr_reg <= qr_reg);
        status.all_ge     = (kl_reg >= ql_reg) && (kr_reg >= qr_reg);
        status.fits       = plmt_pkg::HANDLE_W'(need_w) <= room_w;
        status.reuse      = kind_reg == plmt_pkg::KIND_REUSE;
        status.depth_zero = depth_reg == '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.coord_wr)
        begin
            ctab[slot_reg] <= x_reg;
        end
        if (cmd.coord_rd)
        begin
            case (cmd.coord_sel)
                plmt_pkg::XS_LEFT:
                    xl_reg <= cpos_out_w ? '0 : ctab[plmt_pkg::COORD_AW'(cpos_w - 1'b1)];
                plmt_pkg::XS_RIGHT:
                    xr_reg <= cpos_out_w ? '0 : ctab[plmt_pkg::COORD_AW'(cpos_w - 1'b1)];
                default:
                    xm_reg <= cpos_out_w ? '0 : ctab[plmt_pkg::COORD_AW'(cpos_w - 1'b1)];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_first || cmd.pop_wr)
        begin
            nmem[put_addr_w] <= wr_node_w;
        end
        if (cmd.node_rd)
        begin
            nd_reg <= nmem[p_addr_w];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            stk[plmt_pkg::STACK_AW'(depth_reg)] <= '{
                slope:     mid_w ? s_reg : nd_reg.slope,
                intercept: mid_w ? b_reg : nd_reg.intercept,
                keep:      went_left_w ? nd_reg.right : nd_reg.left,
                went_left: went_left_w
            };
        end
        if (cmd.pop_rd)
        begin
            stk_q_reg <= stk[plmt_pkg::STACK_AW'(depth_reg - 1'b1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= mul_s_w * $signed({1'b0, mul_x_w});
            hold_reg <= cmd.use_node ? nd_reg.intercept : b_reg;
            dst_reg  <= cmd.dst;
        end
        if (cmd.add)
        begin
            case (dst_reg)
                plmt_pkg::D_KL: kl_reg <= sat_w;
                plmt_pkg::D_QL: ql_reg <= sat_w;
                plmt_pkg::D_KR: kr_reg <= sat_w;
                plmt_pkg::D_QR: qr_reg <= sat_w;
                plmt_pkg::D_KM: km_reg <= sat_w;
                plmt_pkg::D_QM: qm_reg <= sat_w;
                default:        v_reg  <= sat_w;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            root_reg   <= in_root;
            p_reg      <= in_root;
            s_reg      <= in_slope;
            b_reg      <= in_intercept;
            x_reg      <= in_x;
            slot_reg   <= in_slot;
            top_in_reg <= in_top;
            l_reg      <= plmt_pkg::POS_W'(1);
            r_reg      <= span_w;
            best_reg   <= plmt_pkg::EMPTY_VALUE;
        end
        if (cmd.step)
        begin
            if (mid_w)
            begin
                s_reg <= nd_reg.slope;
                b_reg <= nd_reg.intercept;
            end
            if (went_left_w)
            begin
                p_reg <= nd_reg.left;
                r_reg <= m_w;
            end
            else
            begin
                p_reg <= nd_reg.right;
                l_reg <= m_w + 1'b1;
            end
        end
        if (cmd.q_step)
        begin
            if (v_reg < best_reg)
            begin
                best_reg <= v_reg;
            end
            if (x_reg <= xm_reg)
            begin
                p_reg <= nd_reg.left;
                r_reg <= m_w;
            end
            else
            begin
                p_reg <= nd_reg.right;
                l_reg <= m_w + 1'b1;
            end
        end
        if (cmd.take_p)
        begin
            result_reg <= p_reg;
        end
        if (cmd.put_first || cmd.pop_wr)
        begin
            result_reg <= top_inc_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= plmt_pkg::ACT_LOAD;
            kind_reg     <= plmt_pkg::KIND_LEAF;
            cnt_reg      <= plmt_pkg::CNT_W'(1);
            pool_top_reg <= '0;
            depth_reg    <= '0;
            full_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cnt_reg <= cfg_count;
            end
            if (cmd.capture)
            begin
                act_reg   <= plmt_pkg::action_t'(in_action);
                depth_reg <= '0;
                full_reg  <= 1'b0;
            end
            if (cmd.set_kind)
            begin
                kind_reg <= cmd.kind;
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
            if (cmd.step || cmd.q_step)
            begin
                depth_reg <= depth_reg + 1'b1;
            end
            if (cmd.pop_rd)
            begin
                depth_reg <= depth_reg - 1'b1;
            end
            if (cmd.set_top)
            begin
                pool_top_reg <= (top_in_reg > POOL_MAX) ? POOL_MAX : top_in_reg;
            end
            if (cmd.put_first || cmd.pop_wr)
            begin
                pool_top_reg <= top_inc_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_top_reg      <= pool_top_reg;
            out_full_reg     <= full_reg;
            out_new_root_reg <= '0;
            out_min_reg      <= '0;
            if (act_reg == plmt_pkg::ACT_INSERT)
            begin
                out_new_root_reg <= full_reg ? root_reg : result_reg;
            end
            if (act_reg == plmt_pkg::ACT_QUERY)
            begin
                out_min_reg <= best_reg;
            end
        end
    end

    assign out_new_root = out_new_root_reg;
    assign out_min      = out_min_reg;
    assign out_top      = out_top_reg;
    assign out_full     = out_full_reg;

`ifndef SYNTHESIS
    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pool_top_reg <= POOL_MAX)
        else $error("pool top beyond pool size");

    a_depth_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= plmt_pkg::DEPTH_W'(plmt_pkg::MAX_LEVELS))
        else $error("path depth beyond level limit");

    a_alloc_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_first || cmd.pop_wr) |-> pool_top_reg < POOL_MAX)
        else $error("node written with a full pool");

    a_alloc_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put_first || cmd.pop_wr) |=> pool_top_reg == $past(pool_top_reg) + 1'b1)
        else $error("pool top did not advance on allocation");
`endif

endmodule

`default_nettype wire
